FILE: rtl/fta_pkg.sv
package fta_pkg;

  // Fixed field widths.
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned THRESH_W = 8;
  localparam int unsigned TRACK_W  = 5;

  // Default table size per bank.
  localparam int unsigned MAX_FACES_DEF = 16;

  // Arithmetic widths of the distance pipeline.
  localparam int unsigned PROD_W   = 2 * COORD_W;
  localparam int unsigned DIST_W   = PROD_W + 1;
  localparam int unsigned NW_W     = THRESH_W + COORD_W;
  localparam int unsigned LIMIT_W  = THRESH_W + 2 * COORD_W;
  localparam int unsigned SCALED_W = DIST_W + THRESH_W;

  // Cycles from a table read issue to the best-candidate update.
  localparam int unsigned PIPE_LAT = 4;
  localparam int unsigned DRAIN_W  = $clog2(PIPE_LAT);

  // Configuration port.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_THRESH_NUM = 1'b0;
  localparam logic REG_THRESH_DEN = 1'b1;
  localparam logic [THRESH_W-1:0] THRESH_NUM_RST = 8'd1;
  localparam logic [THRESH_W-1:0] THRESH_DEN_RST = 8'd5;

  // Request and result codes.
  localparam logic FUNC_DETECT    = 1'b0;
  localparam logic FUNC_FRAME_END = 1'b1;
  localparam logic KIND_VERDICT   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } fta_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic in_ready;
    logic load;
    logic issue;
    logic commit;
  } fta_cmd_t;

  // Datapath and channels to controller.
  typedef struct packed {
    logic in_valid;
    logic in_frame_end;
    logic scan_last;
    logic out_free;
  } fta_status_t;

endpackage

FILE: rtl/fta_if.sv
// Request channel: one detection box or an end-of-frame marker.
interface fta_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [fta_pkg::COORD_W-1:0] det_x;
  logic [fta_pkg::COORD_W-1:0] det_y;
  logic [fta_pkg::COORD_W-1:0] det_width;
  logic [fta_pkg::COORD_W-1:0] det_height;
  logic                        passes_check;

  modport source (
    output valid, func, det_x, det_y, det_width, det_height, passes_check,
    input  ready
  );
  modport sink (
    input  valid, func, det_x, det_y, det_width, det_height, passes_check,
    output ready
  );
endinterface

// Result channel: one verdict or acknowledgement per request.
interface fta_out_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic                        matched;
  logic [fta_pkg::COORD_W-1:0] kept_x;
  logic [fta_pkg::COORD_W-1:0] kept_y;
  logic                        stored;
  logic                        overflow;
  logic [fta_pkg::TRACK_W-1:0] tracked_count;

  modport source (
    output valid, result_kind, matched, kept_x, kept_y, stored, overflow, tracked_count,
    input  ready
  );
  modport sink (
    input  valid, result_kind, matched, kept_x, kept_y, stored, overflow, tracked_count,
    output ready
  );
endinterface

FILE: rtl/fta_ram.sv
module fta_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/fta_ctrl.sv
module fta_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fta_pkg::fta_status_t status_i,
  output fta_pkg::fta_cmd_t    cmd_o
);

  fta_pkg::fta_state_e          state_q, state_d;
  logic [fta_pkg::DRAIN_W-1:0]  drain_q, drain_d;
  logic                         drain_last;

  assign drain_last = (drain_q == fta_pkg::DRAIN_W'(fta_pkg::PIPE_LAT - 1));

  // Next state and drain counter.
  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    case (state_q)
      fta_pkg::ST_IDLE: begin
        drain_d = '0;
        if (status_i.in_valid) begin
          state_d = status_i.in_frame_end ? fta_pkg::ST_COMMIT : fta_pkg::ST_SCAN;
        end
      end
      fta_pkg::ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = fta_pkg::ST_DRAIN;
        end
      end
      fta_pkg::ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_last) begin
          state_d = fta_pkg::ST_COMMIT;
        end
      end
      fta_pkg::ST_COMMIT: begin
        if (status_i.out_free) begin
          state_d = fta_pkg::ST_IDLE;
        end
      end
      default: state_d = fta_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      fta_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = status_i.in_valid;
      end
      fta_pkg::ST_SCAN:   cmd_o.issue  = 1'b1;
      fta_pkg::ST_DRAIN:  cmd_o        = '0;
      fta_pkg::ST_COMMIT: cmd_o.commit = status_i.out_free;
      default:            cmd_o        = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fta_pkg::ST_IDLE;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
    end
  end

endmodule

FILE: rtl/fta_dp.sv
module fta_dp #(
  parameter int unsigned MAX_FACES = fta_pkg::MAX_FACES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fta_pkg::fta_cmd_t             cmd_i,
  input  logic [fta_pkg::THRESH_W-1:0]  thresh_num_i,
  input  logic [fta_pkg::THRESH_W-1:0]  thresh_den_i,
  fta_in_if.sink                        in_if_i,
  fta_out_if.source                     out_if_o,
  output logic                          scan_last_o,
  output logic                          out_free_o
);

  localparam int unsigned DEPTH = 2 * MAX_FACES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IDX_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FACES + 1);
  localparam int unsigned CW    = fta_pkg::COORD_W;

  // Request registers.
  logic                        func_q, check_q;
  logic [CW-1:0]               x_q, y_q, w_q, h_q;

  // Threshold limit num*w*h, built through nw_q and then limit_q after a load.
  logic [fta_pkg::NW_W-1:0]    nw_q;
  logic [fta_pkg::LIMIT_W-1:0] limit_q;

  // Table state.
  logic [DEPTH-1:0]            live_q, live_d;
  logic                        bank_q, bank_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [IDX_W-1:0]            idx_q;

  // Scan pipeline.
  logic                        v1_q, v2_q, v3_q, v4_q;
  logic [IDX_W-1:0]            idx1_q, idx2_q, idx3_q, idx4_q;
  logic [CW-1:0]               sx2_q, sy2_q, sx3_q, sy3_q, sx4_q, sy4_q;
  logic [fta_pkg::PROD_W-1:0]  p1_d, p2_d, p1_q, p2_q;
  logic [fta_pkg::DIST_W-1:0]  d3_q, d4_q;
  logic [fta_pkg::SCALED_W-1:0] sc4_d, sc4_q;
  logic [CW-1:0]               dx, dy, sx1, sy1;

  // Best candidate.
  logic                        found_q, hit;
  logic [fta_pkg::DIST_W-1:0]  bestd_q;
  logic [IDX_W-1:0]            best_q;
  logic [CW-1:0]               bestx_q, besty_q;

  // Memory ports.
  logic [AW-1:0]               raddr, waddr, best_addr;
  logic [2*CW-1:0]             rdata, wdata;
  logic                        we;

  // Commit decisions.
  logic                        take, full;
  logic [CW-1:0]               kx, ky;

  // Result register.
  logic                        out_valid_q;
  logic                        kind_q, matched_q, stored_q, ovf_q;
  logic [CW-1:0]               kept_x_q, kept_y_q;
  logic [fta_pkg::TRACK_W-1:0] track_q;

  assign in_if_i.ready = cmd_i.in_ready;
  assign scan_last_o   = (idx_q == IDX_W'(MAX_FACES - 1));
  assign out_free_o    = !out_valid_q || out_if_o.ready;

  // Old bank is selected by bank_q, new bank by its inverse.
  assign raddr     = bank_q ? AW'(MAX_FACES) + AW'(idx_q) : AW'(idx_q);
  assign best_addr = bank_q ? AW'(MAX_FACES) + AW'(best_q) : AW'(best_q);
  assign waddr     = bank_q ? AW'(cnt_q) : AW'(MAX_FACES) + AW'(cnt_q);

  fta_ram #(
    .WIDTH (2 * CW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Stage 1: absolute differences and the two cross products.
  assign sx1  = rdata[CW-1:0];
  assign sy1  = rdata[2*CW-1:CW];
  assign dx   = (x_q >= sx1) ? x_q - sx1 : sx1 - x_q;
  assign dy   = (y_q >= sy1) ? y_q - sy1 : sy1 - y_q;
  assign p1_d = dx * h_q;
  assign p2_d = dy * w_q;

  // Stage 3: scale the distance by the threshold denominator.
  assign sc4_d = d3_q * thresh_den_i;

  // Stage 4: strict threshold and strict improvement keep the earliest on ties.
  assign hit = v4_q && (sc4_q < fta_pkg::SCALED_W'(limit_q)) &&
               (!found_q || (d4_q < bestd_q));

  // Commit decisions for a detection.
  assign take  = found_q || check_q;
  assign full  = (cnt_q >= CNT_W'(MAX_FACES));
  assign kx    = found_q ? bestx_q : x_q;
  assign ky    = found_q ? besty_q : y_q;
  assign wdata = {ky, kx};
  assign we    = cmd_i.commit && (func_q == fta_pkg::FUNC_DETECT) && take && !full;

  // Next table state on commit.
  always_comb begin
    live_d = live_q;
    bank_d = bank_q;
    cnt_d  = cnt_q;
    if (cmd_i.commit) begin
      if (func_q == fta_pkg::FUNC_FRAME_END) begin
        for (int i = 0; i < DEPTH; i++) begin
          if ((i >= MAX_FACES) == bank_q) begin
            live_d[i] = 1'b0;
          end
        end
        bank_d = ~bank_q;
        cnt_d  = '0;
      end else begin
        if (found_q) begin
          live_d[best_addr] = 1'b0;
        end
        if (take && !full) begin
          live_d[waddr] = 1'b1;
          cnt_d         = cnt_q + 1'b1;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      bank_q      <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      live_q <= live_d;
      bank_q <= bank_d;
      cnt_q  <= cnt_d;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + 1'b1;
      end
      v1_q <= cmd_i.issue && live_q[raddr];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (hit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_if_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_if_i.func;
      check_q <= in_if_i.passes_check;
      x_q     <= in_if_i.det_x;
      y_q     <= in_if_i.det_y;
      w_q     <= in_if_i.det_width;
      h_q     <= in_if_i.det_height;
    end
    nw_q    <= thresh_num_i * w_q;
    limit_q <= nw_q * h_q;

    idx1_q <= idx_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
    sx2_q  <= sx1;
    sy2_q  <= sy1;
    sx3_q  <= sx2_q;
    sy3_q  <= sy2_q;
    sx4_q  <= sx3_q;
    sy4_q  <= sy3_q;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    d3_q   <= fta_pkg::DIST_W'(p1_q) + fta_pkg::DIST_W'(p2_q);
    d4_q   <= d3_q;
    sc4_q  <= sc4_d;

    if (hit) begin
      bestd_q <= d4_q;
      best_q  <= idx4_q;
      bestx_q <= sx4_q;
      besty_q <= sy4_q;
    end

    if (cmd_i.commit) begin
      if (func_q == fta_pkg::FUNC_FRAME_END) begin
        kind_q    <= fta_pkg::KIND_FRAME_END;
        matched_q <= 1'b0;
        kept_x_q  <= '0;
        kept_y_q  <= '0;
        stored_q  <= 1'b0;
        ovf_q     <= 1'b0;
        track_q   <= fta_pkg::TRACK_W'(cnt_q);
      end else begin
        kind_q    <= fta_pkg::KIND_VERDICT;
        matched_q <= found_q;
        kept_x_q  <= kx;
        kept_y_q  <= ky;
        stored_q  <= take && !full;
        ovf_q     <= take && full;
        track_q   <= fta_pkg::TRACK_W'(cnt_d);
      end
    end
  end

  assign out_if_o.valid         = out_valid_q;
  assign out_if_o.result_kind   = kind_q;
  assign out_if_o.matched       = matched_q;
  assign out_if_o.kept_x        = kept_x_q;
  assign out_if_o.kept_y        = kept_y_q;
  assign out_if_o.stored        = stored_q;
  assign out_if_o.overflow      = ovf_q;
  assign out_if_o.tracked_count = track_q;

endmodule

FILE: rtl/face_track_associator.sv
// A detection request is loaded in idle, then the controller scans the old bank, drains the
// distance pipeline and commits, and the next request is taken once the result is registered.
// The scan reads one table entry per cycle through the single read port of the table memory.
// An end-of-frame request goes from idle straight to commit. A commit waits while an earlier
// result is still offered and not taken. Reset is asynchronous and active low; it empties both
// tables, selects bank zero, and loads the thresholds with 1 and 5.
module face_track_associator #(
  parameter int unsigned MAX_FACES = fta_pkg::MAX_FACES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fta_in_if.sink                      in_if_i,
  fta_out_if.source                   out_if_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fta_pkg::APB_AW-1:0]  paddr,
  input  logic [fta_pkg::APB_DW-1:0]  pwdata,
  output logic [fta_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic [fta_pkg::THRESH_W-1:0] thresh_num_q, thresh_den_q;
  logic                         cfg_we;
  fta_pkg::fta_cmd_t            cmd;
  fta_pkg::fta_status_t         status;
  logic                         scan_last, out_free;

  // Configuration registers, one per word.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_num_q <= fta_pkg::THRESH_NUM_RST;
      thresh_den_q <= fta_pkg::THRESH_DEN_RST;
    end else if (cfg_we) begin
      case (paddr[2])
        fta_pkg::REG_THRESH_NUM: thresh_num_q <= pwdata[fta_pkg::THRESH_W-1:0];
        fta_pkg::REG_THRESH_DEN: thresh_den_q <= pwdata[fta_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[2])
      fta_pkg::REG_THRESH_NUM: prdata = fta_pkg::APB_DW'(thresh_num_q);
      fta_pkg::REG_THRESH_DEN: prdata = fta_pkg::APB_DW'(thresh_den_q);
      default:                 prdata = '0;
    endcase
  end

  // Status gathered for the controller.
  assign status.in_valid     = in_if_i.valid;
  assign status.in_frame_end = (in_if_i.func == fta_pkg::FUNC_FRAME_END);
  assign status.scan_last    = scan_last;
  assign status.out_free     = out_free;

  fta_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  fta_dp #(
    .MAX_FACES (MAX_FACES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .thresh_num_i (thresh_num_q),
    .thresh_den_i (thresh_den_q),
    .in_if_i      (in_if_i),
    .out_if_o     (out_if_o),
    .scan_last_o  (scan_last),
    .out_free_o   (out_free)
  );

endmodule

FILE: rtl/fta_checker.sv
module fta_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        result_kind_i,
  input logic                        matched_i,
  input logic [fta_pkg::COORD_W-1:0] kept_x_i,
  input logic [fta_pkg::COORD_W-1:0] kept_y_i,
  input logic                        stored_i,
  input logic                        overflow_i,
  input logic [fta_pkg::TRACK_W-1:0] tracked_count_i
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(result_kind_i) && $stable(matched_i) &&
      $stable(kept_x_i) && $stable(kept_y_i) && $stable(stored_i) &&
      $stable(overflow_i) && $stable(tracked_count_i))
    else $error("result payload changed while stalled");

  // Requests are worked on one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while another is in work");

  // A frame end acknowledgement carries no verdict flags or coordinates.
  a_frame_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == fta_pkg::KIND_FRAME_END) |->
      !matched_i && !stored_i && !overflow_i && (kept_x_i == '0) && (kept_y_i == '0))
    else $error("frame end result carries verdict fields");

  // A match is always either stored or reported as overflow, never both.
  a_verdict_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == fta_pkg::KIND_VERDICT) |->
      !(stored_i && overflow_i) && (!matched_i || stored_i || overflow_i))
    else $error("inconsistent store and overflow flags");

endmodule

bind face_track_associator fta_checker u_fta_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if_i.valid),
  .in_ready_i      (in_if_i.ready),
  .out_valid_i     (out_if_o.valid),
  .out_ready_i     (out_if_o.ready),
  .result_kind_i   (out_if_o.result_kind),
  .matched_i       (out_if_o.matched),
  .kept_x_i        (out_if_o.kept_x),
  .kept_y_i        (out_if_o.kept_y),
  .stored_i        (out_if_o.stored),
  .overflow_i      (out_if_o.overflow),
  .tracked_count_i (out_if_o.tracked_count)
);

FILE: verif/tb_face_track_associator.sv
module tb_face_track_associator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXF        = fta_pkg::MAX_FACES_DEF;
  // Span of one detection from acceptance to the next acceptance.
  localparam int TURN        = MAXF + 6;
  localparam int CLK_PERIOD  = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic                        func;
    logic [fta_pkg::COORD_W-1:0] x;
    logic [fta_pkg::COORD_W-1:0] y;
    logic [fta_pkg::COORD_W-1:0] w;
    logic [fta_pkg::COORD_W-1:0] h;
    logic                        pass;
  } face_req_t;

  typedef struct packed {
    logic                        kind;
    logic                        matched;
    logic [fta_pkg::COORD_W-1:0] kx;
    logic [fta_pkg::COORD_W-1:0] ky;
    logic                        stored;
    logic                        ovf;
    logic [fta_pkg::TRACK_W-1:0] count;
  } face_verdict_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [fta_pkg::APB_AW-1:0] paddr;
  logic [fta_pkg::APB_DW-1:0] pwdata;
  logic [fta_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  fta_in_if  req_if ();
  fta_out_if resp_if ();

  face_track_associator u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if_i  (req_if),
    .out_if_o (resp_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow of the two track banks and the thresholds.
  logic [fta_pkg::COORD_W-1:0]  trk_x [2*MAXF];
  logic [fta_pkg::COORD_W-1:0]  trk_y [2*MAXF];
  bit                           trk_live [2*MAXF];
  bit                           trk_bank;
  int unsigned                  trk_count;
  logic [fta_pkg::THRESH_W-1:0] thr_num = fta_pkg::THRESH_NUM_RST;
  logic [fta_pkg::THRESH_W-1:0] thr_den = fta_pkg::THRESH_DEN_RST;

  face_req_t     stim_q [$];
  face_verdict_t verdict_q [$];
  face_req_t     req_cur;
  int            queued_cnt   = 0;
  int            answered_cnt = 0;
  int            fail_cnt     = 0;
  int            idle_cycles  = 0;
  bit            req_taken    = 1'b0;
  int            req_gap      = 0;
  int            resp_stall   = 0;
  int            calm_left    = 0;
  bit            calm         = 1'b0;

  // Faces the generator keeps in view across frames.
  int scene_x [$];
  int scene_y [$];
  int scene_w [$];
  int scene_h [$];

  // Associates one request with the previous frame's tracks and updates the shadow.
  function automatic face_verdict_t associate_request(face_req_t r);
    face_verdict_t v;
    int unsigned   oldb;
    int unsigned   newb;
    int unsigned   best;
    bit            found;
    logic [63:0]   lim;
    logic [63:0]   d;
    logic [63:0]   bestd;
    logic [63:0]   dx;
    logic [63:0]   dy;
    logic [fta_pkg::COORD_W-1:0] kx;
    logic [fta_pkg::COORD_W-1:0] ky;
    v    = '0;
    oldb = trk_bank ? MAXF : 0;
    newb = trk_bank ? 0 : MAXF;
    if (r.func == fta_pkg::FUNC_FRAME_END) begin
      v.kind  = fta_pkg::KIND_FRAME_END;
      v.count = trk_count[fta_pkg::TRACK_W-1:0];
      for (int i = 0; i < MAXF; i++) trk_live[oldb+i] = 1'b0;
      trk_bank  = ~trk_bank;
      trk_count = 0;
      return v;
    end
    found = 1'b0;
    best  = 0;
    bestd = '0;
    kx    = r.x;
    ky    = r.y;
    // Zero width or height can never match.
    if (r.w != 0 && r.h != 0) begin
      lim = 64'(thr_num) * 64'(r.w) * 64'(r.h);
      for (int i = 0; i < MAXF; i++) begin
        if (trk_live[oldb+i]) begin
          dx = (r.x > trk_x[oldb+i]) ? r.x - trk_x[oldb+i] : trk_x[oldb+i] - r.x;
          dy = (r.y > trk_y[oldb+i]) ? r.y - trk_y[oldb+i] : trk_y[oldb+i] - r.y;
          d  = dx * 64'(r.h) + dy * 64'(r.w);
          // Strictly closer only, so the earliest slot keeps a tie.
          if (d * 64'(thr_den) < lim && (!found || d < bestd)) begin
            found = 1'b1;
            bestd = d;
            best  = i;
          end
        end
      end
    end
    if (found) begin
      kx = trk_x[oldb+best];
      ky = trk_y[oldb+best];
      trk_live[oldb+best] = 1'b0;
    end
    if (found || r.pass) begin
      if (trk_count < MAXF) begin
        trk_x[newb+trk_count]    = kx;
        trk_y[newb+trk_count]    = ky;
        trk_live[newb+trk_count] = 1'b1;
        trk_count++;
        v.stored = 1'b1;
      end else begin
        v.ovf = 1'b1;
      end
    end
    v.kind    = fta_pkg::KIND_VERDICT;
    v.matched = found;
    v.kx      = kx;
    v.ky      = ky;
    v.count   = trk_count[fta_pkg::TRACK_W-1:0];
    return v;
  endfunction

  function automatic void check_field(string name, logic kind, int unsigned want,
                                      int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch (kind %0b): expected %0d, actual %0d",
               $time, name, kind, want, got);
      fail_cnt++;
    end
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic face_req_t mk_req(logic func, int x, int y, int w, int h, logic pass);
    face_req_t r;
    r.func = func;
    r.x    = x[fta_pkg::COORD_W-1:0];
    r.y    = y[fta_pkg::COORD_W-1:0];
    r.w    = w[fta_pkg::COORD_W-1:0];
    r.h    = h[fta_pkg::COORD_W-1:0];
    r.pass = pass;
    return r;
  endfunction

  function automatic int jitter(int c, int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // Face sizes: mostly moderate, some tiny, some huge.
  function automatic int face_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(16, 300);
    if (r < 85) return $urandom_range(1, 15);
    return $urandom_range(301, 4095);
  endfunction

  task automatic push_req(face_req_t r);
    stim_q.insert(stim_q.size(), r);
    queued_cnt++;
  endtask

  // One frame: jittered detections of the faces in view, new faces, noise, frame end.
  task automatic gen_frame();
    face_req_t frame_q [$];
    face_req_t d;
    int        n_new;
    int        fx;
    int        fy;
    int        fw;
    int        fh;
    for (int i = scene_x.size() - 1; i >= 0; i--) begin
      if ($urandom_range(0, 19) == 0) begin
        scene_x.delete(i);
        scene_y.delete(i);
        scene_w.delete(i);
        scene_h.delete(i);
      end else if ($urandom_range(0, 9) != 0) begin
        fw = scene_w[i];
        if ($urandom_range(0, 7) == 0) fw = jitter(fw, fw / 4);
        frame_q.insert(frame_q.size(),
                       mk_req(fta_pkg::FUNC_DETECT, jitter(scene_x[i], scene_w[i] / 12),
                              jitter(scene_y[i], scene_h[i] / 12), fw, scene_h[i],
                              1'($urandom_range(0, 1))));
      end
    end
    // Now and then a crowded frame, to fill the new list.
    n_new = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 3);
    for (int i = 0; i < n_new; i++) begin
      fx = $urandom_range(0, 4095);
      fy = $urandom_range(0, 4095);
      fw = face_size();
      fh = face_size();
      if (scene_x.size() < 24) begin
        scene_x.insert(scene_x.size(), fx);
        scene_y.insert(scene_y.size(), fy);
        scene_w.insert(scene_w.size(), fw);
        scene_h.insert(scene_h.size(), fh);
      end
      d = mk_req(fta_pkg::FUNC_DETECT, fx, fy, fw, fh, $urandom_range(0, 9) != 0);
      frame_q.insert($urandom_range(0, frame_q.size()), d);
    end
    if ($urandom_range(0, 3) == 0) begin
      d = mk_req(fta_pkg::FUNC_DETECT, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095),
                 1'($urandom_range(0, 1)));
      frame_q.insert($urandom_range(0, frame_q.size()), d);
    end
    foreach (frame_q[i]) push_req(frame_q[i]);
    push_req(mk_req(fta_pkg::FUNC_FRAME_END, $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), 1'($urandom_range(0, 1))));
    if ($urandom_range(0, 15) == 0) begin
      push_req(mk_req(fta_pkg::FUNC_FRAME_END, 0, 0, 0, 0, 1'b0));
    end
  endtask

  // Waits until every request has been answered and the block has gone quiet.
  task automatic settle();
    while (answered_cnt < queued_cnt) @(negedge clk_i);
    repeat (TURN) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [fta_pkg::THRESH_W-1:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = fta_pkg::APB_DW'(val);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == fta_pkg::REG_THRESH_NUM) thr_num = val;
    else thr_den = val;
  endtask

  task automatic cfg_check(logic idx, logic [fta_pkg::THRESH_W-1:0] want);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata[fta_pkg::THRESH_W-1:0] != want) begin
      $display("%0t: register %0d readback: expected %0d, actual %0d",
               $time, idx, want, prdata[fta_pkg::THRESH_W-1:0]);
      fail_cnt++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Request driver: holds a request until it is taken, then waits out a random gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!(req_if.valid && !req_taken)) begin
      if (req_gap > 0) begin
        req_gap      <= req_gap - 1;
        req_if.valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        req_cur                = stim_q.pop_front();
        req_if.func           <= req_cur.func;
        req_if.det_x          <= req_cur.x;
        req_if.det_y          <= req_cur.y;
        req_if.det_width      <= req_cur.w;
        req_if.det_height     <= req_cur.h;
        req_if.passes_check   <= req_cur.pass;
        req_if.valid          <= 1'b1;
        req_gap               <= pick_gap();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure, with calm stretches where neither side pauses.
  always @(negedge clk_i) begin
    if (calm_left == 0) begin
      calm      = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(50, 300);
    end else begin
      calm_left = calm_left - 1;
    end
    if (!rst_ni) begin
      resp_if.ready <= 1'b0;
    end else if (resp_stall > 0) begin
      resp_stall    <= resp_stall - 1;
      resp_if.ready <= 1'b0;
    end else begin
      resp_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) resp_stall <= pick_gap();
    end
  end

  // Monitor: checks results, predicts accepted requests, and watches for a hang.
  always @(posedge clk_i) begin : mon_blk
    face_verdict_t want;
    bit            resp_fire;
    req_taken = req_if.valid && req_if.ready;
    resp_fire = resp_if.valid && resp_if.ready;
    if (rst_ni) begin
      if (resp_fire) begin
        answered_cnt++;
        if (verdict_q.size() == 0) begin
          $display("%0t: result with no request pending: expected none, actual kind %0b",
                   $time, resp_if.result_kind);
          fail_cnt++;
        end else begin
          want = verdict_q.pop_front();
          check_field("result_kind", want.kind, want.kind, resp_if.result_kind);
          check_field("matched", want.kind, want.matched, resp_if.matched);
          check_field("kept_x", want.kind, want.kx, resp_if.kept_x);
          check_field("kept_y", want.kind, want.ky, resp_if.kept_y);
          check_field("stored", want.kind, want.stored, resp_if.stored);
          check_field("overflow", want.kind, want.ovf, resp_if.overflow);
          check_field("tracked_count", want.kind, want.count, resp_if.tracked_count);
        end
      end
      if (req_taken) verdict_q.insert(verdict_q.size(), associate_request(req_cur));
      if (req_taken || resp_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: nothing moved for %0d cycles", $time, idle_cycles);
        $display("tb_face_track_associator failed");
        $finish;
      end
    end
  end

  initial begin : stim_blk
    int num_steps [8];
    int den_steps [8];
    num_steps = '{1, 255, 1, 255, 0, 3, 2, 1};
    den_steps = '{5, 255, 255, 1, 7, 0, 3, 5};

    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_if.valid         = 1'b0;
    req_if.func          = fta_pkg::FUNC_DETECT;
    req_if.det_x         = '0;
    req_if.det_y         = '0;
    req_if.det_width     = '0;
    req_if.det_height    = '0;
    req_if.passes_check  = 1'b0;
    resp_if.ready        = 1'b0;
    for (int i = 0; i < 2 * MAXF; i++) trk_live[i] = 1'b0;
    trk_bank  = 1'b0;
    trk_count = 0;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // First frame at reset thresholds: extremes, unchecked boxes, zero sizes.
    push_req(mk_req(fta_pkg::FUNC_DETECT, 100, 100, 50, 50, 1'b1));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 200, 100, 50, 50, 1'b1));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 0, 0, 4095, 4095, 1'b1));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 4095, 4095, 1, 1, 1'b1));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 500, 500, 40, 40, 1'b0));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 300, 300, 0, 40, 1'b1));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 300, 300, 40, 0, 1'b1));
    push_req(mk_req(fta_pkg::FUNC_FRAME_END, 0, 0, 0, 0, 1'b0));
    // Second frame: a tie between two equally close faces goes to the earlier one,
    // then exact and near matches, a zero-size box and a miss without the check flag.
    push_req(mk_req(fta_pkg::FUNC_DETECT, 150, 100, 500, 500, 1'b0));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 150, 100, 500, 500, 1'b0));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 4095, 4095, 1, 1, 1'b0));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 1, 1, 4095, 4095, 1'b0));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 300, 300, 0, 0, 1'b1));
    push_req(mk_req(fta_pkg::FUNC_DETECT, 4095, 0, 4095, 4095, 1'b0));
    push_req(mk_req(fta_pkg::FUNC_FRAME_END, 4095, 4095, 4095, 4095, 1'b1));
    // Empty frames.
    push_req(mk_req(fta_pkg::FUNC_FRAME_END, 0, 0, 0, 0, 1'b0));
    push_req(mk_req(fta_pkg::FUNC_FRAME_END, 0, 0, 0, 0, 1'b0));

    // Random frames under a sweep of thresholds, zero numerator and denominator included.
    for (int p = 0; p < 8; p++) begin
      settle();
      cfg_write(fta_pkg::REG_THRESH_NUM, num_steps[p][fta_pkg::THRESH_W-1:0]);
      cfg_write(fta_pkg::REG_THRESH_DEN, den_steps[p][fta_pkg::THRESH_W-1:0]);
      cfg_check(fta_pkg::REG_THRESH_NUM, thr_num);
      cfg_check(fta_pkg::REG_THRESH_DEN, thr_den);
      begin : fill_blk
        int start;
        start = queued_cnt;
        while (queued_cnt - start < PHASE_ITEMS) gen_frame();
      end
    end
    settle();

    if (fail_cnt == 0) begin
      $display("tb_face_track_associator passed");
    end else begin
      $display("tb_face_track_associator failed");
    end
    $finish;
  end

endmodule
